// File: rtl/midpoint_ellipse_rasterizer_core_defines.svh
// Assertion macros shared by the rasterizer RTL.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_CORE_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MER_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MER_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mer_pkg.sv
package mer_pkg;

    localparam int COORD_BITS_DEF = 11;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_START_T,
        ST_START_INIT,
        ST_R1_MA,
        ST_R1_MB,
        ST_R1_UPD,
        ST_R1_END_M,
        ST_R1_END,
        ST_R2_MA,
        ST_R2_MB,
        ST_R2_UPD,
        ST_EMIT
    } seq_state_t;

    typedef enum logic [1:0] {
        RG_IDLE = 2'd0,
        RG_ONE  = 2'd1,
        RG_TWO  = 2'd2
    } region_t;

endpackage

// File: rtl/midpoint_ellipse_rasterizer_core.sv
// A start item runs ST_SQ_A, ST_SQ_B, ST_START_T and ST_START_INIT, then ST_EMIT;
// a region step runs its MA, MB and UPD states, then ST_EMIT (or ST_IDLE when region 2
// has no step left); closing region 1 adds ST_R1_END_M and ST_R1_END before ST_EMIT.
// Items are taken one at a time; every product uses the single shared multiplier.
// Reset (aresetn low, synchronous): sequencer idle, no figure active, output empty.
`include "midpoint_ellipse_rasterizer_core_defines.svh"

module midpoint_ellipse_rasterizer_core #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
    localparam int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W       = COORD_BITS + 2,
    localparam int OUT_TDATA_W = ((4 * OUT_W + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // center_x, center_y, corner_x, corner_y (lowest first)
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // mode
    input  logic [0:0]             s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // x_plus, x_minus, y_plus, y_minus (lowest first)
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // final_group
    output logic                   m_tlast
);

    localparam int C      = COORD_BITS;
    localparam int OFF_W  = C + 1;
    localparam int A_W    = 2 * C;
    localparam int B_W    = C + 2;
    localparam int PROD_W = A_W + B_W;
    localparam int DEC_W  = 4 * C;

    mer_pkg::seq_state_t state_reg, state_next;
    mer_pkg::region_t    region_reg, region_next;

    logic [C-1:0]      cx_reg, cx_next;
    logic [C-1:0]      cy_reg, cy_next;
    logic [C-1:0]      rx_reg, rx_next;
    logic [C-1:0]      ry_reg, ry_next;
    logic [OFF_W-1:0]  ox_reg, ox_next;
    logic [OFF_W-1:0]  oy_reg, oy_next;
    logic [A_W-1:0]    a_reg, a_next;
    logic [A_W-1:0]    b_reg, b_next;
    logic [PROD_W-1:0] t1_reg, t1_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic signed [DEC_W-1:0] dec_reg, dec_next;
    logic              final_reg, final_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   m_tlast_reg, m_tlast_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [A_W-1:0] mul_a;
    logic [B_W-1:0] mul_b;
    logic           s_accept;
    logic           out_load;

    logic [C-1:0] in_cx, in_cy, in_kx, in_ky;
    logic         in_mode;

    logic signed [DEC_W-1:0] a_ext, b_ext, t1_ext, prod_ext, tb_ext;
    logic                    dec_neg;
    logic                    r1_go, r2_go, r1_end_can, r2_next_can;
    logic [PROD_W-1:0]       q2_new;
    logic [OFF_W-1:0]        ox_step;
    logic [OUT_W-1:0]        x_plus, x_minus, y_plus, y_minus;

    assign in_cx   = s_tdata[C-1:0];
    assign in_cy   = s_tdata[2*C-1:C];
    assign in_kx   = s_tdata[3*C-1:2*C];
    assign in_ky   = s_tdata[4*C-1:3*C];
    assign in_mode = s_tuser[0];

    assign s_accept = s_tvalid && s_tready;

    // Shared multiplier, registered every cycle
    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign a_ext    = signed'(DEC_W'(a_reg));
    assign b_ext    = signed'(DEC_W'(b_reg));
    assign t1_ext   = signed'(DEC_W'(t1_reg));
    assign prod_ext = signed'(DEC_W'(prod_reg));
    assign dec_neg  = dec_reg[DEC_W-1];

    // b*(ox-1) = prod - b in region 2; a*(oy-1) = t1 - a in region 1
    assign tb_ext = dec_neg ? (t1_ext <<< 3) : ((t1_ext - a_ext) <<< 3);

    assign r1_go      = (oy_reg != '0) && (t1_reg >= prod_reg);
    assign r2_go      = (ox_reg != '0) && (t1_reg < prod_reg);
    assign r1_end_can = (rx_reg != '0) && (PROD_W'(a_reg) < prod_reg);
    assign ox_step    = dec_neg ? ox_reg : ox_reg - OFF_W'(1);
    assign q2_new     = dec_neg ? prod_reg : prod_reg - PROD_W'(b_reg);
    assign r2_next_can = (ox_step != '0)
                      && (({1'b0, t1_reg} + (PROD_W + 1)'(a_reg)) < {1'b0, q2_new});

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mer_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (in_mode == mer_pkg::MODE_START) begin
                        state_next = mer_pkg::ST_SQ_A;
                    end else begin
                        case (region_reg)
                            mer_pkg::RG_ONE: state_next = mer_pkg::ST_R1_MA;
                            mer_pkg::RG_TWO: state_next = mer_pkg::ST_R2_MA;
                            default:         state_next = mer_pkg::ST_IDLE;
                        endcase
                    end
                end
            end
            mer_pkg::ST_SQ_A:       state_next = mer_pkg::ST_SQ_B;
            mer_pkg::ST_SQ_B:       state_next = mer_pkg::ST_START_T;
            mer_pkg::ST_START_T:    state_next = mer_pkg::ST_START_INIT;
            mer_pkg::ST_START_INIT: state_next = mer_pkg::ST_EMIT;
            mer_pkg::ST_R1_MA:      state_next = mer_pkg::ST_R1_MB;
            mer_pkg::ST_R1_MB:      state_next = mer_pkg::ST_R1_UPD;
            mer_pkg::ST_R1_UPD: begin
                state_next = r1_go ? mer_pkg::ST_EMIT : mer_pkg::ST_R1_END_M;
            end
            mer_pkg::ST_R1_END_M:   state_next = mer_pkg::ST_R1_END;
            mer_pkg::ST_R1_END:     state_next = mer_pkg::ST_EMIT;
            mer_pkg::ST_R2_MA:      state_next = mer_pkg::ST_R2_MB;
            mer_pkg::ST_R2_MB:      state_next = mer_pkg::ST_R2_UPD;
            mer_pkg::ST_R2_UPD: begin
                state_next = r2_go ? mer_pkg::ST_EMIT : mer_pkg::ST_IDLE;
            end
            mer_pkg::ST_EMIT: begin
                if (out_load) begin
                    state_next = mer_pkg::ST_IDLE;
                end
            end
            default: state_next = mer_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands and handshake controls
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        s_tready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            mer_pkg::ST_IDLE: s_tready = 1'b1;
            mer_pkg::ST_SQ_A: begin
                mul_a = A_W'(rx_reg);
                mul_b = B_W'(rx_reg);
            end
            mer_pkg::ST_SQ_B: begin
                mul_a = A_W'(ry_reg);
                mul_b = B_W'(ry_reg);
            end
            mer_pkg::ST_START_T: begin
                mul_a = a_reg;
                mul_b = B_W'(ry_reg);
            end
            mer_pkg::ST_R1_MA: begin
                mul_a = a_reg;
                mul_b = B_W'(oy_reg);
            end
            mer_pkg::ST_R1_MB: begin
                mul_a = b_reg;
                mul_b = B_W'(ox_reg) + B_W'(1);
            end
            mer_pkg::ST_R1_END_M: begin
                mul_a = b_reg;
                mul_b = B_W'(rx_reg);
            end
            mer_pkg::ST_R2_MA: begin
                mul_a = a_reg;
                mul_b = B_W'(oy_reg) + B_W'(1);
            end
            mer_pkg::ST_R2_MB: begin
                mul_a = b_reg;
                mul_b = B_W'(ox_reg);
            end
            mer_pkg::ST_EMIT: out_load = !m_tvalid_reg || m_tready;
            default: begin
            end
        endcase
    end

    // Datapath
    always_comb begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        t1_next     = t1_reg;
        dec_next    = dec_reg;
        final_next  = final_reg;
        region_next = region_reg;
        case (state_reg)
            mer_pkg::ST_IDLE: begin
                if (s_accept && in_mode == mer_pkg::MODE_START) begin
                    cx_next = in_cx;
                    cy_next = in_cy;
                    rx_next = (in_kx >= in_cx) ? in_kx - in_cx : in_cx - in_kx;
                    ry_next = (in_ky >= in_cy) ? in_ky - in_cy : in_cy - in_ky;
                end
            end
            mer_pkg::ST_SQ_B:    a_next = prod_reg[A_W-1:0];
            mer_pkg::ST_START_T: b_next = prod_reg[A_W-1:0];
            mer_pkg::ST_START_INIT: begin
                dec_next    = (b_ext <<< 2) - (prod_ext <<< 2) + a_ext;
                ox_next     = '0;
                oy_next     = OFF_W'(ry_reg);
                region_next = mer_pkg::RG_ONE;
                final_next  = 1'b0;
            end
            mer_pkg::ST_R1_MB: t1_next = prod_reg;
            mer_pkg::ST_R1_UPD: begin
                if (r1_go) begin
                    ox_next    = ox_reg + OFF_W'(1);
                    final_next = 1'b0;
                    if (dec_neg) begin
                        dec_next = dec_reg + (prod_ext <<< 3) + (b_ext <<< 2);
                    end else begin
                        oy_next  = oy_reg - OFF_W'(1);
                        dec_next = dec_reg + (prod_ext <<< 3) - tb_ext + (b_ext <<< 2);
                    end
                end
            end
            mer_pkg::ST_R1_END: begin
                ox_next     = OFF_W'(rx_reg);
                oy_next     = '0;
                dec_next    = (a_ext <<< 2) - (prod_ext <<< 2) + b_ext;
                final_next  = !r1_end_can;
                region_next = r1_end_can ? mer_pkg::RG_TWO : mer_pkg::RG_IDLE;
            end
            mer_pkg::ST_R2_MB: t1_next = prod_reg;
            mer_pkg::ST_R2_UPD: begin
                if (!r2_go) begin
                    region_next = mer_pkg::RG_IDLE;
                end else begin
                    oy_next = oy_reg + OFF_W'(1);
                    ox_next = ox_step;
                    if (dec_neg) begin
                        dec_next = dec_reg + (t1_ext <<< 3) + (a_ext <<< 2);
                    end else begin
                        dec_next = dec_reg + (t1_ext <<< 3)
                                 - ((prod_ext - b_ext) <<< 3) + (a_ext <<< 2);
                    end
                    final_next  = !r2_next_can;
                    region_next = r2_next_can ? mer_pkg::RG_TWO : mer_pkg::RG_IDLE;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register
    assign x_plus  = OUT_W'(cx_reg) + OUT_W'(ox_reg);
    assign x_minus = OUT_W'(cx_reg) - OUT_W'(ox_reg);
    assign y_plus  = OUT_W'(cy_reg) + OUT_W'(oy_reg);
    assign y_minus = OUT_W'(cy_reg) - OUT_W'(oy_reg);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_TDATA_W'({y_minus, y_plus, x_minus, x_plus});
            m_tlast_next  = final_reg;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mer_pkg::ST_IDLE;
            region_reg   <= mer_pkg::RG_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            region_reg   <= region_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        t1_reg      <= t1_next;
        prod_reg    <= prod_next;
        dec_reg     <= dec_next;
        final_reg   <= final_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // An advance with no figure active is dropped without work
    `MER_ASSERT_NEXT(a_idle_advance, aclk, aresetn, s_accept && in_mode == mer_pkg::MODE_ADVANCE && region_reg == mer_pkg::RG_IDLE, state_reg == mer_pkg::ST_IDLE, "advance with no figure started work")
    // Region 2 is only held while a step in x remains
    `MER_ASSERT_NOW(a_r2_offset, aclk, aresetn, region_reg == mer_pkg::RG_TWO && state_reg == mer_pkg::ST_IDLE, ox_reg != '0, "region 2 held with zero x offset")
    // Region 2 update only runs on an active region-2 figure
    `MER_ASSERT_NOW(a_r2_upd_region, aclk, aresetn, state_reg == mer_pkg::ST_R2_UPD, region_reg == mer_pkg::RG_TWO, "region 2 update outside region 2")
    // A new result appears only out of the emit step
    `MER_ASSERT_NOW(a_emit_src, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg) == mer_pkg::ST_EMIT, "result loaded outside emit step")

endmodule

// File: test/midpoint_ellipse_rasterizer_core_tb.sv
`timescale 1ns / 100ps

module midpoint_ellipse_rasterizer_core_tb;

    localparam int COORD_W     = mer_pkg::COORD_BITS_DEF;
    localparam int IN_TDATA_W  = ((4 * COORD_W + 7) / 8) * 8;
    localparam int OUT_W       = COORD_W + 2;
    localparam int OUT_TDATA_W = ((4 * OUT_W + 7) / 8) * 8;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1050;

    typedef logic [COORD_W-1:0] coord_t;

    // Highest field first, so the packed layout lines up with {m_tdata, m_tlast}
    typedef struct packed {
        logic [OUT_W-1:0] y_minus;
        logic [OUT_W-1:0] y_plus;
        logic [OUT_W-1:0] x_minus;
        logic [OUT_W-1:0] x_plus;
        logic             final_group;
    } point_group_t;

    // Tracks the figure being traced and holds the point groups still owed.
    class ellipse_tracker;
        coord_t           ctr_x, ctr_y;
        longint           rad_x, rad_y, off_x, off_y, dcsn;
        mer_pkg::region_t rgn;
        point_group_t     pending[$];
        int               mismatches, groups_checked, figures_closed;

        function new();
            ctr_x = '0;
            ctr_y = '0;
            rad_x = 0;
            rad_y = 0;
            off_x = 0;
            off_y = 0;
            dcsn  = 0;
            rgn   = mer_pkg::RG_IDLE;
            mismatches     = 0;
            groups_checked = 0;
            figures_closed = 0;
        endfunction

        function void push_group(bit fin);
            point_group_t g;
            longint       v;
            v = longint'(ctr_x) + off_x;  g.x_plus  = v[OUT_W-1:0];
            v = longint'(ctr_x) - off_x;  g.x_minus = v[OUT_W-1:0];
            v = longint'(ctr_y) + off_y;  g.y_plus  = v[OUT_W-1:0];
            v = longint'(ctr_y) - off_y;  g.y_minus = v[OUT_W-1:0];
            g.final_group = fin;
            pending.insert(pending.size(), g);
        endfunction

        function bit lower_can_step(longint a, longint b);
            return off_x > 0 && a * (off_y + 1) < b * off_x;
        endfunction

        // Returns 1 when the item is owed a point group.
        function bit accept_item(logic mode, coord_t cx, coord_t cy, coord_t kx, coord_t ky);
            longint a, b;
            if (mode == mer_pkg::MODE_START) begin
                ctr_x = cx;
                ctr_y = cy;
                rad_x = (kx >= cx) ? longint'(kx) - cx : longint'(cx) - kx;
                rad_y = (ky >= cy) ? longint'(ky) - cy : longint'(cy) - ky;
                a = rad_x * rad_x;
                b = rad_y * rad_y;
                off_x = 0;
                off_y = rad_y;
                dcsn  = 4 * b - 4 * a * rad_y + a;
                rgn   = mer_pkg::RG_ONE;
                push_group(1'b0);
                return 1'b1;
            end
            a = rad_x * rad_x;
            b = rad_y * rad_y;
            if (rgn == mer_pkg::RG_ONE) begin
                if (off_y > 0 && a * off_y >= b * (off_x + 1)) begin
                    off_x = off_x + 1;
                    if (dcsn < 0) begin
                        dcsn += 8 * b * off_x + 4 * b;
                    end else begin
                        off_y -= 1;
                        dcsn += 8 * b * off_x - 8 * a * off_y + 4 * b;
                    end
                    push_group(1'b0);
                    return 1'b1;
                end
                // region 1 done: jump to the x-axis point
                off_x = rad_x;
                off_y = 0;
                dcsn  = 4 * a - 4 * b * rad_x + b;
                if (lower_can_step(a, b)) begin
                    rgn = mer_pkg::RG_TWO;
                    push_group(1'b0);
                end else begin
                    rgn = mer_pkg::RG_IDLE;
                    push_group(1'b1);
                end
                return 1'b1;
            end
            if (rgn == mer_pkg::RG_TWO) begin
                if (!lower_can_step(a, b)) begin
                    rgn = mer_pkg::RG_IDLE;
                    return 1'b0;
                end
                off_y += 1;
                if (dcsn < 0) begin
                    dcsn += 8 * a * off_y + 4 * a;
                end else begin
                    off_x -= 1;
                    dcsn += 8 * a * off_y - 8 * b * off_x + 4 * a;
                end
                if (lower_can_step(a, b)) begin
                    push_group(1'b0);
                end else begin
                    rgn = mer_pkg::RG_IDLE;
                    push_group(1'b1);
                end
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void check_group(point_group_t got);
            point_group_t want;
            if (pending.size() == 0) begin
                $error("unexpected point group %h", got);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            groups_checked++;
            if (got.final_group)
                figures_closed++;
            if (got.x_plus !== want.x_plus) begin
                $error("x_plus: expected %0d, got %0d", $signed(want.x_plus), $signed(got.x_plus));
                mismatches++;
            end
            if (got.x_minus !== want.x_minus) begin
                $error("x_minus: expected %0d, got %0d", $signed(want.x_minus),
                       $signed(got.x_minus));
                mismatches++;
            end
            if (got.y_plus !== want.y_plus) begin
                $error("y_plus: expected %0d, got %0d", $signed(want.y_plus), $signed(got.y_plus));
                mismatches++;
            end
            if (got.y_minus !== want.y_minus) begin
                $error("y_minus: expected %0d, got %0d", $signed(want.y_minus),
                       $signed(got.y_minus));
                mismatches++;
            end
            if (got.final_group !== want.final_group) begin
                $error("final_group: expected %0b, got %0b", want.final_group, got.final_group);
                mismatches++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    ellipse_tracker tracker;
    bit             no_gaps;
    int             busy_items;
    int             start_items;
    int             advance_items;
    int             quiet_cycles = 0;

    midpoint_ellipse_rasterizer_core #(.COORD_BITS(COORD_W)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic mode, coord_t cx, coord_t cy, coord_t kx, coord_t ky);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = '0;
        s_tdata[4*COORD_W-1:0] = {ky, kx, cy, cx};
        do @(posedge aclk); while (!s_tready);
        if (tracker.accept_item(mode, cx, cy, kx, ky))
            busy_items++;
        if (mode == mer_pkg::MODE_START)
            start_items++;
        else
            advance_items++;
        @(negedge aclk);
    endtask

    task automatic step_figure();
        send_item(mer_pkg::MODE_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom));
    endtask

    task automatic trace_out(int cap);
        int n;
        n = 0;
        while (tracker.rgn != mer_pkg::RG_IDLE && n < cap) begin
            step_figure();
            n++;
        end
    endtask

    // Corner at distance r from c, on a random side where it fits.
    function automatic coord_t corner_at(coord_t c, int r);
        if ($urandom_range(0, 1) && int'(c) >= r)
            return coord_t'(int'(c) - r);
        if (int'(c) + r <= COORD_MAX)
            return coord_t'(int'(c) + r);
        if (int'(c) >= r)
            return coord_t'(int'(c) - r);
        return coord_t'(COORD_MAX);
    endfunction

    // result side
    initial begin
        int           stall;
        point_group_t got;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = {m_tdata[4*OUT_W-1:0], m_tlast};
            tracker.check_group(got);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        coord_t cx, cy, kx, ky;
        int     pick, rx, ry;
        tracker      = new();
        no_gaps      = 1'b0;
        busy_items   = 0;
        start_items  = 0;
        advance_items = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = mer_pkg::MODE_START;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // advance with nothing active
        step_figure();
        // full-range corners, mirrored in both directions
        send_item(mer_pkg::MODE_START, '0, '0, coord_t'(COORD_MAX), coord_t'(COORD_MAX));
        step_figure();
        step_figure();
        // restart while the previous figure is active
        send_item(mer_pkg::MODE_START, coord_t'(COORD_MAX), coord_t'(COORD_MAX), '0, '0);
        step_figure();
        // zero x radius: the (0,0) group closes it, then one ignored advance
        send_item(mer_pkg::MODE_START, 11'd100, 11'd100, 11'd100, 11'd105);
        trace_out(4);
        step_figure();
        // zero y radius
        send_item(mer_pkg::MODE_START, 11'd500, 11'd600, 11'd510, 11'd600);
        trace_out(4);
        // degenerate point
        send_item(mer_pkg::MODE_START, 11'd7, 11'd7, 11'd7, 11'd7);
        trace_out(4);
        // small figure with the corner below and left, through both regions
        send_item(mer_pkg::MODE_START, 11'd50, 11'd60, 11'd47, 11'd58);
        trace_out(20);

        busy_items = 0;
        while (busy_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                no_gaps = ~no_gaps;
            cx = coord_t'($urandom);
            cy = coord_t'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                rx = $urandom_range(0, 24);
                ry = $urandom_range(0, 24);
                kx = corner_at(cx, rx);
                ky = corner_at(cy, ry);
            end else if (pick < 95) begin
                rx = $urandom_range(25, 150);
                ry = $urandom_range(0, 150);
                if ($urandom_range(0, 1)) begin
                    pick = rx;
                    rx = ry;
                    ry = pick;
                end
                kx = corner_at(cx, rx);
                ky = corner_at(cy, ry);
            end else begin
                kx = coord_t'($urandom);
                ky = coord_t'($urandom);
            end
            if ($urandom_range(0, 19) == 0)
                step_figure();
            send_item(mer_pkg::MODE_START, cx, cy, kx, ky);
            if (pick >= 95 || $urandom_range(0, 9) == 0)
                trace_out($urandom_range(0, 40));
            else
                trace_out(5000);
            if ($urandom_range(0, 4) == 0)
                step_figure();
        end

        // drop valid right away so the last item is not offered again
        s_tvalid = 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d start and %0d advance items; %0d point groups checked.",
                 start_items, advance_items, tracker.groups_checked);
        $display("Traced %0d figures to their final group.", tracker.figures_closed);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
